[rtl/nslsb_pkg.sv]
// shared types and constants for the line shift bound block
`default_nettype none
package nslsb_pkg;

    localparam int NUM_W  = 64;
    localparam int DEN_W  = 33;
    localparam int DIST_W = 65;

    localparam logic [1:0] OP_LOAD_IN  = 2'd0;
    localparam logic [1:0] OP_LOAD_OUT = 2'd1;
    localparam logic [1:0] OP_COMPUTE  = 2'd2;

    localparam logic [1:0] ST_CONV  = 2'd0;
    localparam logic [1:0] ST_INF   = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    localparam logic [31:0] ALPHA_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ALPHA_MIN = 32'h8000_0000;

    typedef struct packed {
        logic               go;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [NUM_W-1:0]   quo;
    } t_div_rsp;

endpackage
`default_nettype wire

[rtl/nearest_set_line_shift_bound.sv]
// top level: point stores, sequencer, shared multiplier and divider
// a load writes one point into its store; a compute scans the point sets for a start pair and,
// per round, runs the divider and then scans every point of both sets
// throughput: one item at a time, busy stays high until the result beat
// the result beat is a one-cycle o_valid strobe, the receiver cannot stall
// reset: synchronous active low, clears both point counts and the sequencer
`default_nettype none
module nearest_set_line_shift_bound #(
    parameter int MAX_POINTS     = 64,
    parameter int MAX_ITERATIONS = 64,
    parameter int FRAC_BITS      = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  i_op,
    input  wire logic signed [31:0] i_axial_pos,
    input  wire logic [31:0] i_perp_sq,
    input  wire logic        i_direction,
    output logic             busy,
    output logic             o_valid,
    output logic signed [31:0] o_alpha,
    output logic [1:0]       o_status
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = $clog2(MAX_ITERATIONS + 1);
    localparam int DSW = nslsb_pkg::DIST_W;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHK    = 5'd1;
    localparam logic [4:0] S_ST_RD  = 5'd2;
    localparam logic [4:0] S_ST_CMP = 5'd3;
    localparam logic [4:0] S_OA_RD  = 5'd4;
    localparam logic [4:0] S_OA_CMP = 5'd5;
    localparam logic [4:0] S_PR_RD  = 5'd6;
    localparam logic [4:0] S_PR_LD  = 5'd7;
    localparam logic [4:0] S_SQO    = 5'd8;
    localparam logic [4:0] S_SQI    = 5'd9;
    localparam logic [4:0] S_NUM    = 5'd10;
    localparam logic [4:0] S_DIV_GO = 5'd11;
    localparam logic [4:0] S_DIV_WT = 5'd12;
    localparam logic [4:0] S_D_RD   = 5'd13;
    localparam logic [4:0] S_D_MAG  = 5'd14;
    localparam logic [4:0] S_D_MUL  = 5'd15;
    localparam logic [4:0] S_D_CMP  = 5'd16;
    localparam logic [4:0] S_CONV   = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    logic [4:0]         r_state;
    logic [CW-1:0]      r_in_cnt;
    logic [CW-1:0]      r_out_cnt;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_ii;
    logic [AW-1:0]      r_io;
    logic [AW-1:0]      r_ni;
    logic [AW-1:0]      r_no;
    logic [IW-1:0]      r_iter;
    logic               r_dir;
    logic               r_side;
    logic               r_vld;
    logic signed [31:0] r_bpos;
    logic signed [31:0] r_xi;
    logic [31:0]        r_yi;
    logic [31:0]        r_yo;
    logic signed [33:0] r_den;
    logic [31:0]        r_mag;
    logic [31:0]        r_ys;
    logic [63:0]        r_acc;
    logic [63:0]        r_prod;
    logic [63:0]        r_num;
    logic [DSW-1:0]     r_best;
    logic signed [31:0] r_alpha;
    logic [1:0]         r_status;

    logic [63:0]        w_in_rd;
    logic [63:0]        w_out_rd;
    logic               w_acc;
    logic               w_we_in;
    logic               w_we_out;
    logic [AW-1:0]      w_in_ra;
    logic [AW-1:0]      w_out_ra;
    logic [63:0]        w_sq;
    logic signed [31:0] w_in_pos;
    logic signed [31:0] w_out_pos;
    logic signed [31:0] w_x;
    logic [31:0]        w_y;
    logic signed [32:0] w_d;
    logic signed [32:0] w_pd;
    logic [DSW-1:0]     w_dist;
    logic               w_better;
    logic [CW-1:0]      w_next;
    logic               w_in_last;
    logic               w_out_last;
    logic               w_ahead;
    logic               w_start_better;
    logic               w_sign;
    logic [31:0]        w_sat;
    logic [31:0]        w_inf;
    logic [IW-1:0]      w_iter_n;

    nslsb_pkg::t_div_req w_req;
    nslsb_pkg::t_div_rsp w_rsp;

    assign w_acc    = start && (r_state == S_IDLE);
    assign w_we_in  = w_acc && (i_op == nslsb_pkg::OP_LOAD_IN)
                      && (r_in_cnt < CW'(MAX_POINTS));
    assign w_we_out = w_acc && (i_op == nslsb_pkg::OP_LOAD_OUT)
                      && (r_out_cnt < CW'(MAX_POINTS));
    assign w_in_ra  = (r_state == S_PR_RD) ? r_ii : r_idx;
    assign w_out_ra = (r_state == S_PR_RD) ? r_io : r_idx;

    nslsb_store #(.DEPTH(MAX_POINTS)) u_inner (
        .i_clk   (i_clk),
        .i_we    (w_we_in),
        .i_waddr (r_in_cnt[AW-1:0]),
        .i_wdata ({i_axial_pos, i_perp_sq}),
        .i_raddr (w_in_ra),
        .o_rdata (w_in_rd)
    );

    nslsb_store #(.DEPTH(MAX_POINTS)) u_outer (
        .i_clk   (i_clk),
        .i_we    (w_we_out),
        .i_waddr (r_out_cnt[AW-1:0]),
        .i_wdata ({i_axial_pos, i_perp_sq}),
        .i_raddr (w_out_ra),
        .o_rdata (w_out_rd)
    );

    assign w_req.go  = (r_state == S_DIV_GO);
    assign w_req.num = r_num[63] ? (~r_num + 64'd1) : r_num;
    assign w_req.den = r_den[33] ? 33'(-r_den) : r_den[32:0];

    nslsb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // shared multiplier
    assign w_sq = r_mag * r_mag;

    assign w_in_pos  = w_in_rd[63:32];
    assign w_out_pos = w_out_rd[63:32];
    assign w_x = r_side ? w_out_pos : w_in_pos;
    assign w_y = r_side ? w_out_rd[31:0] : w_in_rd[31:0];
    assign w_d = 33'(w_x) - 33'(r_alpha);
    assign w_pd = 33'(w_out_pos) - 33'(w_in_pos);
    assign w_dist = {1'b0, r_prod} + DSW'({r_ys, {FRAC_BITS{1'b0}}});
    assign w_better = r_side ? (w_dist < r_best) : (r_best < w_dist);
    assign w_next = CW'(r_idx) + CW'(1);
    assign w_in_last  = (w_next == r_in_cnt);
    assign w_out_last = (w_next == r_out_cnt);
    assign w_ahead = r_dir ? (w_out_pos > r_bpos) : (w_out_pos < r_bpos);
    assign w_start_better = r_dir ? (w_in_pos < r_bpos) : (w_in_pos > r_bpos);
    assign w_sign = r_num[63] ^ r_den[33];
    assign w_inf = r_dir ? nslsb_pkg::ALPHA_MAX : nslsb_pkg::ALPHA_MIN;
    assign w_iter_n = r_iter + IW'(1);

    always_comb begin
        if (!w_sign) begin
            w_sat = (w_rsp.quo > 64'h7FFF_FFFF) ? nslsb_pkg::ALPHA_MAX : w_rsp.quo[31:0];
        end else begin
            w_sat = (w_rsp.quo > 64'h8000_0000) ? nslsb_pkg::ALPHA_MIN
                                                : (~w_rsp.quo[31:0] + 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_vld     <= 1'b0;
        end else begin
            r_vld <= (r_state == S_DONE);
            case (r_state)
                S_IDLE: begin
                    if (w_we_in) begin
                        r_in_cnt <= r_in_cnt + CW'(1);
                    end
                    if (w_we_out) begin
                        r_out_cnt <= r_out_cnt + CW'(1);
                    end
                    if (w_acc && (i_op == nslsb_pkg::OP_COMPUTE)) begin
                        r_dir   <= i_direction;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_idx <= '0;
                    if (r_in_cnt == '0) begin
                        r_alpha  <= w_inf;
                        r_status <= nslsb_pkg::ST_INF;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_ST_RD;
                    end
                end
                S_ST_RD: r_state <= S_ST_CMP;
                S_ST_CMP: begin
                    if ((r_idx == '0) || w_start_better) begin
                        r_bpos <= w_in_pos;
                        r_ii   <= r_idx;
                    end
                    if (w_in_last) begin
                        r_idx <= '0;
                        if (r_out_cnt == '0) begin
                            r_alpha  <= w_inf;
                            r_status <= nslsb_pkg::ST_INF;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_OA_RD;
                        end
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_ST_RD;
                    end
                end
                S_OA_RD: r_state <= S_OA_CMP;
                S_OA_CMP: begin
                    if (w_ahead) begin
                        r_io    <= r_idx;
                        r_iter  <= '0;
                        r_state <= S_PR_RD;
                    end else if (w_out_last) begin
                        r_alpha  <= w_inf;
                        r_status <= nslsb_pkg::ST_INF;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_OA_RD;
                    end
                end
                S_PR_RD: r_state <= S_PR_LD;
                S_PR_LD: begin
                    r_xi    <= w_in_pos;
                    r_yi    <= w_in_rd[31:0];
                    r_yo    <= w_out_rd[31:0];
                    r_den   <= {w_pd, 1'b0};
                    r_mag   <= w_out_pos[31] ? (~w_out_pos + 32'd1) : w_out_pos;
                    r_state <= S_SQO;
                end
                S_SQO: begin
                    r_acc   <= w_sq;
                    r_mag   <= r_xi[31] ? (~r_xi + 32'd1) : r_xi;
                    r_state <= S_SQI;
                end
                S_SQI: begin
                    r_prod  <= w_sq;
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num <= r_acc - r_prod + 64'({r_yo, {FRAC_BITS{1'b0}}})
                             - 64'({r_yi, {FRAC_BITS{1'b0}}});
                    if (r_den == '0) begin
                        r_alpha  <= '0;
                        r_status <= nslsb_pkg::ST_ZERO;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: r_state <= S_DIV_WT;
                S_DIV_WT: begin
                    if (w_rsp.done) begin
                        r_alpha <= w_sat;
                        r_side  <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_D_RD;
                    end
                end
                S_D_RD: r_state <= S_D_MAG;
                S_D_MAG: begin
                    r_mag   <= w_d[32] ? 32'(-w_d) : w_d[31:0];
                    r_ys    <= w_y;
                    r_state <= S_D_MUL;
                end
                S_D_MUL: begin
                    r_prod  <= w_sq;
                    r_state <= S_D_CMP;
                end
                S_D_CMP: begin
                    if ((r_idx == '0) || w_better) begin
                        r_best <= w_dist;
                        if (r_side) begin
                            r_no <= r_idx;
                        end else begin
                            r_ni <= r_idx;
                        end
                    end
                    if (!r_side && w_in_last) begin
                        r_side  <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_D_RD;
                    end else if (r_side && w_out_last) begin
                        r_state <= S_CONV;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_D_RD;
                    end
                end
                S_CONV: begin
                    if ((r_ni == r_ii) && (r_no == r_io)) begin
                        r_status <= nslsb_pkg::ST_CONV;
                        r_state  <= S_DONE;
                    end else begin
                        r_ii   <= r_ni;
                        r_io   <= r_no;
                        r_iter <= w_iter_n;
                        if (w_iter_n == IW'(MAX_ITERATIONS)) begin
                            r_status <= nslsb_pkg::ST_LIMIT;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_PR_RD;
                        end
                    end
                end
                S_DONE: begin
                    r_in_cnt  <= '0;
                    r_out_cnt <= '0;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_vld;
    assign o_alpha  = r_alpha;
    assign o_status = r_status;

endmodule
`default_nettype wire

[rtl/nslsb_store.sv]
// point store: one write port, one registered read port
`default_nettype none
module nslsb_store #(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [63:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [63:0]        o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/nslsb_div.sv]
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none
module nslsb_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nslsb_pkg::t_div_req i_req,
    output nslsb_pkg::t_div_rsp    o_rsp
);

    localparam int NW = nslsb_pkg::NUM_W;
    localparam int DW = nslsb_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DW:0]       r_rem;
    logic [NW-1:0]     r_q;
    logic [DW-1:0]     r_den;
    logic [DW:0]       n_sh;
    logic              n_ge;

    assign n_sh = {r_rem[DW-1:0], r_q[NW-1]};
    assign n_ge = (n_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= n_ge ? (n_sh - {1'b0, r_den}) : n_sh;
                r_q   <= {r_q[NW-2:0], n_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule
`default_nettype wire

[rtl/nslsb_check.sv]
// port checker for the line shift bound block, bound to the top level
`default_nettype none
module nslsb_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  i_op,
    input wire logic        o_valid,
    input wire logic [31:0] o_alpha,
    input wire logic [1:0]  o_status
);

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result beat without a finished compute");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == nslsb_pkg::OP_COMPUTE)) |=> busy)
        else $error("compute beat did not start the sequencer");

    a_inf_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == nslsb_pkg::ST_INF)) |->
        ((o_alpha == nslsb_pkg::ALPHA_MAX) || (o_alpha == nslsb_pkg::ALPHA_MIN)))
        else $error("infinite bound without saturated alpha");

    a_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == nslsb_pkg::ST_ZERO)) |-> (o_alpha == '0))
        else $error("zero denominator with nonzero alpha");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("reset did not idle the block");

endmodule

bind nearest_set_line_shift_bound nslsb_check u_nslsb_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_op     (i_op),
    .o_valid  (o_valid),
    .o_alpha  (o_alpha),
    .o_status (o_status)
);
`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the line shift bound block: directed and random point sets, bound prediction
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 64;
    localparam int NITER = 64;
    localparam int FB = 16;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int STALL_LIMIT = 400000;
    localparam int NUM_ITEMS = 1550;

    typedef struct {
        logic [1:0] op;
        logic [31:0] pos;
        logic [31:0] perp;
        logic dir;
    } t_cmd;

    typedef struct {
        logic [31:0] alpha;
        logic [1:0] status;
    } t_bound;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] i_op = '0;
    logic signed [31:0] i_axial_pos = '0;
    logic [31:0] i_perp_sq = '0;
    logic i_direction = 1'b0;
    logic busy, o_valid;
    logic signed [31:0] o_alpha;
    logic [1:0] o_status;

    t_cmd cmd_q[$];
    t_bound bound_q[$];
    int total_cmds = 0;
    int issued = 0;
    int errors = 0;
    int quiet_cycles = 0;

    longint in_x[NPTS], out_x[NPTS];
    longint in_y[NPTS], out_y[NPTS];
    int in_n = 0, out_n = 0;

    nearest_set_line_shift_bound DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_op(i_op),
        .i_axial_pos(i_axial_pos), .i_perp_sq(i_perp_sq), .i_direction(i_direction),
        .busy(busy), .o_valid(o_valid), .o_alpha(o_alpha), .o_status(o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [64:0] dist2(longint x, longint y, longint a);
        longint d;
        logic [63:0] m;
        logic [63:0] sq;
        logic [64:0] ys;
        d = x - a;
        m = (d < 0) ? -d : d;
        sq = m * m;
        ys = 65'(y) << FB;
        return {1'b0, sq} + ys;
    endfunction

    function automatic t_bound bound_of(logic dir);
        t_bound r;
        int ii, io, ni, no;
        longint xo, xi, num, den, q, a;
        logic [64:0] best, cur;
        a = 0;
        r.alpha = dir ? nslsb_pkg::ALPHA_MAX : nslsb_pkg::ALPHA_MIN;
        r.status = nslsb_pkg::ST_INF;
        if (in_n == 0) return r;
        ii = 0;
        for (int i = 1; i < in_n; i++)
            if (dir ? (in_x[i] < in_x[ii]) : (in_x[i] > in_x[ii])) ii = i;
        io = out_n;
        for (int i = 0; i < out_n; i++)
            if (dir ? (out_x[i] > in_x[ii]) : (out_x[i] < in_x[ii])) begin
                io = i;
                break;
            end
        if (io >= out_n) return r;
        for (int it = 0; it < NITER; it++) begin
            xo = out_x[io];
            xi = in_x[ii];
            num = (xo * xo - xi * xi) + ((out_y[io] <<< FB) - (in_y[ii] <<< FB));
            den = 2 * (xo - xi);
            if (den == 0) begin
                r.alpha = '0;
                r.status = nslsb_pkg::ST_ZERO;
                return r;
            end
            q = num / den;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            a = q;
            ni = 0;
            best = dist2(in_x[0], in_y[0], a);
            for (int i = 1; i < in_n; i++) begin
                cur = dist2(in_x[i], in_y[i], a);
                if (best < cur) begin
                    best = cur;
                    ni = i;
                end
            end
            no = 0;
            best = dist2(out_x[0], out_y[0], a);
            for (int i = 1; i < out_n; i++) begin
                cur = dist2(out_x[i], out_y[i], a);
                if (cur < best) begin
                    best = cur;
                    no = i;
                end
            end
            if (ni == ii && no == io) begin
                r.alpha = a[31:0];
                r.status = nslsb_pkg::ST_CONV;
                return r;
            end
            ii = ni;
            io = no;
        end
        r.alpha = a[31:0];
        r.status = nslsb_pkg::ST_LIMIT;
        return r;
    endfunction

    task automatic apply_cmd(t_cmd c);
        case (c.op)
            nslsb_pkg::OP_LOAD_IN: if (in_n < NPTS) begin
                in_x[in_n] = longint'(signed'(c.pos));
                in_y[in_n] = longint'(c.perp);
                in_n++;
            end
            nslsb_pkg::OP_LOAD_OUT: if (out_n < NPTS) begin
                out_x[out_n] = longint'(signed'(c.pos));
                out_y[out_n] = longint'(c.perp);
                out_n++;
            end
            nslsb_pkg::OP_COMPUTE: begin
                bound_q = {bound_q, bound_of(c.dir)};
                in_n = 0;
                out_n = 0;
            end
            default: ;
        endcase
    endtask

    task automatic add(logic [1:0] op, logic [31:0] pos, logic [31:0] perp, logic dir);
        t_cmd c;
        c.op = op;
        c.pos = pos;
        c.perp = perp;
        c.dir = dir;
        cmd_q = {cmd_q, c};
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [31:0] rand_perp();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom_range(0, 1 << 22);
        endcase
    endfunction

    task automatic add_set();
        int ni, no;
        ni = ($urandom_range(0, 40) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 7);
        no = ($urandom_range(0, 40) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 7);
        while (ni + no > 0) begin
            if (ni > 0 && (no == 0 || $urandom_range(0, 1))) begin
                add(nslsb_pkg::OP_LOAD_IN, rand_pos(), rand_perp(), $urandom_range(0, 1));
                ni--;
            end else begin
                add(nslsb_pkg::OP_LOAD_OUT, rand_pos(), rand_perp(), $urandom_range(0, 1));
                no--;
            end
            if ($urandom_range(0, 30) == 0) add(OP_NOP, $urandom(), $urandom(), $urandom_range(0, 1));
        end
        add(nslsb_pkg::OP_COMPUTE, $urandom(), $urandom(), $urandom_range(0, 1));
    endtask

    // driver
    always @(posedge i_clk) begin
        t_cmd c;
        int idle_pct;
        logic take;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take = !start;
            if (start && !busy) begin
                c = cmd_q.pop_front();
                apply_cmd(c);
                issued++;
                take = 1'b1;
            end
            if (take) begin
                idle_pct = (issued < total_cmds / 3) ? 28 :
                           (issued < 2 * total_cmds / 3) ? 45 : 0;
                if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    c = cmd_q[0];
                    start <= 1'b1;
                    i_op <= c.op;
                    i_axial_pos <= c.pos;
                    i_perp_sq <= c.perp;
                    i_direction <= c.dir;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_bound e;
        if (i_rst_n && o_valid) begin
            if (bound_q.size() == 0) begin
                $error("result beat with nothing expected: alpha %h status %0d",
                       o_alpha, o_status);
                errors++;
            end else begin
                e = bound_q.pop_front();
                if (o_alpha !== e.alpha) begin
                    $error("alpha: expected %h actual %h", e.alpha, o_alpha);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // directed
        add(nslsb_pkg::OP_COMPUTE, 32'h0, 32'h0, 1'b0);
        add(nslsb_pkg::OP_COMPUTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add(nslsb_pkg::OP_LOAD_IN, 32'h0001_0000, 32'h0, 1'b1);
        add(nslsb_pkg::OP_LOAD_OUT, 32'hFFFF_0000, 32'h0, 1'b0);
        add(nslsb_pkg::OP_COMPUTE, 32'h0, 32'h0, 1'b1);
        add(OP_NOP, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
        add(nslsb_pkg::OP_LOAD_IN, 32'h0, 32'h0001_0000, 1'b0);
        add(nslsb_pkg::OP_LOAD_OUT, 32'h0, 32'h0, 1'b0);
        add(nslsb_pkg::OP_LOAD_OUT, 32'h000A_0000, 32'h0, 1'b0);
        add(nslsb_pkg::OP_COMPUTE, 32'h0, 32'h0, 1'b1);
        add(nslsb_pkg::OP_LOAD_IN, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add(nslsb_pkg::OP_LOAD_OUT, 32'h7FFF_FFFF, 32'h0, 1'b1);
        add(nslsb_pkg::OP_COMPUTE, 32'h0, 32'h0, 1'b1);
        add(nslsb_pkg::OP_LOAD_IN, 32'h7FFF_FFFF, 32'h0, 1'b1);
        add(nslsb_pkg::OP_LOAD_OUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        add(nslsb_pkg::OP_COMPUTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add(nslsb_pkg::OP_LOAD_IN, 32'h0002_0000, 32'h0004_0000, 1'b0);
        add(nslsb_pkg::OP_LOAD_IN, 32'h0000_0000, 32'h0, 1'b0);
        add(nslsb_pkg::OP_LOAD_OUT, 32'hFFFC_0000, 32'h0001_0000, 1'b0);
        add(nslsb_pkg::OP_LOAD_OUT, 32'hFFFE_0000, 32'h0009_0000, 1'b0);
        add(nslsb_pkg::OP_COMPUTE, 32'h0, 32'h0, 1'b0);
        // random point sets, with loose noise beats
        while (cmd_q.size() < NUM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                add(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom_range(0, 1));
            else
                add_set();
        end
        total_cmds = cmd_q.size();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (cmd_q.size() > 0 || start || bound_q.size() > 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && bound_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
